// ===== hdl/assert_macros.svh =====
// Assertion macros used by the message ring FIFO datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define MRF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define MRF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/mrf_pkg.sv =====
// Shared types and constants of the message ring FIFO.
`default_nettype none

package mrf_pkg;

   // Default geometry of the queue.
   localparam int SLOTS_DEF   = 16;
   localparam int MAX_LEN_DEF = 8;

   // Request opcodes.
   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BUSY    = 2'd1,
      ST_LEN_ERR = 2'd2,
      ST_PENDING = 2'd3
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;       // a request transaction is taken at this edge
      logic start_bytes;  // popped length is known and nonzero: fetch the first byte
      logic emit_empty;   // popped slot holds no bytes: send the single empty result
      logic emit_byte;    // send the fetched byte and fetch the next one unless it is the last
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic pop_nonempty; // the offered request is a pop and a message is stored
      logic len_zero;     // the fetched length of the popped slot is zero
      logic byte_last;    // the byte being sent is the final one of the message
   } stat_type;

endpackage

`default_nettype wire

// ===== hdl/mrf_ctrl.sv =====
// Controller state machine that sequences requests and message pops.
`default_nettype none

module mrf_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire mrf_pkg::stat_type stat,
   output mrf_pkg::cmd_type       cmd
);

   typedef enum logic [2:0] {
      S_IDLE     = 3'b001,
      S_POP_LEN  = 3'b010,
      S_POP_BYTE = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Requests are taken only while idle.
   assign busy = (state_ff != S_IDLE);

   // Next state and command decode.
   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      cmd.accept = start && (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.accept && stat.pop_nonempty) begin
               state_in = S_POP_LEN;
            end
         end
         S_POP_LEN: begin
            if (stat.len_zero) begin
               cmd.emit_empty = 1'b1;
               state_in       = S_IDLE;
            end else begin
               cmd.start_bytes = 1'b1;
               state_in        = S_POP_BYTE;
            end
         end
         S_POP_BYTE: begin
            cmd.emit_byte = 1'b1;
            if (stat.byte_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/mrf_datapath.sv =====
// Datapath of the message ring FIFO: indices, staging, memories and result registers.
`default_nettype none

`include "assert_macros.svh"

module mrf_datapath #(
   parameter  int SLOTS   = mrf_pkg::SLOTS_DEF,
   parameter  int MAX_LEN = mrf_pkg::MAX_LEN_DEF,
   localparam int CNT_W   = $clog2(SLOTS + 1),
   localparam int LEN_W   = $clog2(MAX_LEN + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mrf_pkg::cmd_type  cmd,
   output mrf_pkg::stat_type      stat,
   input  wire logic [1:0]        req_opcode,
   input  wire logic [7:0]        req_data_byte,
   input  wire logic              req_last_byte,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_out_last,
   output logic [LEN_W-1:0]       rsp_out_length,
   output logic [CNT_W-1:0]       rsp_queued_count,
   output logic                   rsp_is_empty,
   output logic                   rsp_is_full,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [CNT_W-1:0]  csr_data
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int DEPTH = SLOTS * MAX_LEN;
   localparam int BA_W  = $clog2(DEPTH);
   localparam logic [BA_W-1:0] ROW_SIZE = BA_W'(MAX_LEN);

   // Queue control state.
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [LEN_W-1:0] staged_ff, staged_in;
   logic             overflow_ff, overflow_in;
   logic             blocked_ff, blocked_in;
   logic [CNT_W-1:0] limit_ff, limit_in;

   // Pop stream state.
   logic [IDX_W-1:0] pop_slot_ff, pop_slot_in;
   logic [LEN_W-1:0] pop_len_ff;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [7:0]       byte_rd_ff;

   // Result registers.
   logic                 rsp_valid_ff, rsp_valid_in;
   mrf_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic [7:0]           rsp_byte_ff, rsp_byte_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [LEN_W-1:0]     rsp_len_ff, rsp_len_in;
   logic [CNT_W-1:0]     rsp_count_ff;
   logic                 rsp_empty_ff;
   logic                 rsp_full_ff;

   // Memories and their ports.
   logic [7:0]       byte_ram [DEPTH];
   logic [LEN_W-1:0] len_ram  [SLOTS];
   logic             byte_we, byte_re;
   logic [BA_W-1:0]  byte_wa, byte_ra;
   logic             len_we, len_re;
   logic [IDX_W-1:0] len_wa;
   logic [LEN_W-1:0] len_wd;
   logic [LEN_W-1:0] rd_idx;

   // Working values.
   logic [CNT_W-1:0] lim;
   logic             full;
   logic             blocked_nx;
   logic             overflow_nx;
   logic [LEN_W-1:0] staged_nx;
   mrf_pkg::op_type  op;

   // Next slot index, wrapping at the effective limit.
   function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] limit);
      logic [CNT_W-1:0] n;
      n = CNT_W'(idx) + CNT_W'(1);
      return (n >= limit) ? '0 : n[IDX_W-1:0];
   endfunction

   // Effective slot limit, saturated into one to SLOTS.
   always_comb begin
      priority if (limit_ff == '0) begin
         lim = CNT_W'(1);
      end else if (limit_ff > CNT_W'(SLOTS)) begin
         lim = CNT_W'(SLOTS);
      end else begin
         lim = limit_ff;
      end
   end

   assign full = (count_ff >= lim);
   assign op   = mrf_pkg::op_type'(req_opcode);

   // Status toward the controller.
   assign stat.pop_nonempty = (op == mrf_pkg::OP_POP) && (count_ff != '0);
   assign stat.len_zero     = (pop_len_ff == '0);
   assign stat.byte_last    = ((idx_ff + LEN_W'(1)) == pop_len_ff);

   // Register write port: always ready.
   assign csr_ready = 1'b1;
   assign limit_in  = csr_valid ? csr_data : limit_ff;

   // Request execution and result selection.
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      staged_in     = staged_ff;
      overflow_in   = overflow_ff;
      blocked_in    = blocked_ff;
      pop_slot_in   = pop_slot_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = mrf_pkg::ST_OK;
      rsp_byte_in   = 8'd0;
      rsp_last_in   = 1'b1;
      rsp_len_in    = '0;
      byte_we       = 1'b0;
      byte_wa       = BA_W'(tail_ff) * ROW_SIZE + BA_W'(staged_ff);
      byte_re       = 1'b0;
      rd_idx        = '0;
      len_we        = 1'b0;
      len_wa        = tail_ff;
      len_wd        = '0;
      len_re        = 1'b0;
      blocked_nx    = blocked_ff | full;
      overflow_nx   = overflow_ff;
      staged_nx     = staged_ff;

      if (cmd.accept) begin
         unique case (op)
            mrf_pkg::OP_PUSH: begin
               rsp_valid_in = 1'b1;
               if (staged_ff >= LEN_W'(MAX_LEN)) begin
                  overflow_nx = 1'b1;
               end else begin
                  byte_we   = !blocked_nx;
                  staged_nx = staged_ff + LEN_W'(1);
               end
               if (!req_last_byte) begin
                  rsp_status_in = mrf_pkg::ST_PENDING;
                  staged_in     = staged_nx;
                  overflow_in   = overflow_nx;
                  blocked_in    = blocked_nx;
               end else begin
                  priority if (overflow_nx) begin
                     rsp_status_in = mrf_pkg::ST_LEN_ERR;
                  end else if (blocked_nx) begin
                     rsp_status_in = mrf_pkg::ST_BUSY;
                  end else begin
                     // Commit the staged message to the tail slot.
                     rsp_status_in = mrf_pkg::ST_OK;
                     len_we        = 1'b1;
                     len_wd        = staged_nx;
                     tail_in       = advance(tail_ff, lim);
                     count_in      = count_ff + CNT_W'(1);
                  end
                  staged_in   = '0;
                  overflow_in = 1'b0;
                  blocked_in  = 1'b0;
               end
            end
            mrf_pkg::OP_POP: begin
               if (count_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = mrf_pkg::ST_BUSY;
               end else begin
                  // Fetch the head length, clear it and release the slot.
                  len_re      = 1'b1;
                  len_we      = 1'b1;
                  len_wa      = head_ff;
                  len_wd      = '0;
                  pop_slot_in = head_ff;
                  head_in     = advance(head_ff, lim);
                  count_in    = count_ff - CNT_W'(1);
               end
            end
            mrf_pkg::OP_CLEAR: begin
               rsp_valid_in = 1'b1;
               head_in      = '0;
               tail_in      = '0;
               count_in     = '0;
               staged_in    = '0;
               overflow_in  = 1'b0;
               blocked_in   = 1'b0;
            end
            mrf_pkg::OP_NOP: begin
               rsp_valid_in = 1'b1;
            end
            default: begin
               rsp_valid_in = 1'b1;
            end
         endcase
      end

      // Empty slot popped: a single result with no byte.
      if (cmd.emit_empty) begin
         rsp_valid_in = 1'b1;
      end

      // First byte fetch of a popped message.
      if (cmd.start_bytes) begin
         byte_re = 1'b1;
         rd_idx  = '0;
         idx_in  = '0;
      end

      // Send the fetched byte and, unless it is the last, fetch the one after it.
      if (cmd.emit_byte) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = byte_rd_ff;
         rsp_last_in  = stat.byte_last;
         rsp_len_in   = pop_len_ff;
         byte_re      = !stat.byte_last;
         rd_idx       = idx_ff + LEN_W'(1);
         idx_in       = idx_ff + LEN_W'(1);
      end

      byte_ra = BA_W'(pop_slot_ff) * ROW_SIZE + BA_W'(rd_idx);
   end

   // Message byte memory: push writes, pop stream reads.
   always_ff @(posedge clock) begin
      if (byte_we) begin
         byte_ram[byte_wa] <= req_data_byte;
      end
      if (byte_re) begin
         byte_rd_ff <= byte_ram[byte_ra];
      end
   end

   // Message length memory: read before write at the same edge.
   always_ff @(posedge clock) begin
      if (len_re) begin
         pop_len_ff <= len_ram[head_ff];
      end
      if (len_we) begin
         len_ram[len_wa] <= len_wd;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         staged_ff    <= '0;
         overflow_ff  <= 1'b0;
         blocked_ff   <= 1'b0;
         limit_ff     <= CNT_W'(SLOTS);
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         staged_ff    <= staged_in;
         overflow_ff  <= overflow_in;
         blocked_ff   <= blocked_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers of the pop stream and the result.
   always_ff @(posedge clock) begin
      pop_slot_ff <= pop_slot_in;
      idx_ff      <= idx_in;
      if (rsp_valid_in) begin
         rsp_status_ff <= rsp_status_in;
         rsp_byte_ff   <= rsp_byte_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_len_ff    <= rsp_len_in;
         rsp_count_ff  <= count_in;
         rsp_empty_ff  <= (count_in == '0);
         rsp_full_ff   <= (count_in >= lim);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_byte     = rsp_byte_ff;
   assign rsp_out_last     = rsp_last_ff;
   assign rsp_out_length   = rsp_len_ff;
   assign rsp_queued_count = rsp_count_ff;
   assign rsp_is_empty     = rsp_empty_ff;
   assign rsp_is_full      = rsp_full_ff;

   // The stored count never passes the number of physical slots.
   `MRF_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(SLOTS), "count above slots")
   // The staging count saturates at the maximum message length.
   `MRF_ASSERT_IMP(a_staged_bound, clock, reset, 1'b1, staged_ff <= LEN_W'(MAX_LEN), "staging overrun")
   // A byte is only sent from inside a nonempty popped message.
   `MRF_ASSERT_IMP(a_pop_byte_range, clock, reset, cmd.emit_byte, (pop_len_ff != '0) && (idx_ff < pop_len_ff), "pop index out of message")
   // A result that is not the final one is followed by another in the next cycle.
   `MRF_ASSERT_NEXT(a_stream_gapless, clock, reset, rsp_valid_ff && !rsp_last_ff, rsp_valid_ff, "gap in pop stream")

endmodule

`default_nettype wire

// ===== hdl/message_ring_fifo.sv =====
// Push and clear transactions give one result in the cycle after acceptance; busy stays low.
// A pop of an empty queue behaves the same way.
// A pop of a message of L bytes holds busy while its length is read and its L bytes are sent;
// its results follow one per cycle, paced by the registered length and byte memory reads.
// A pop of a slot with zero length holds busy while its length is read, then gives its single result.
// Synchronous reset empties the queue and sets the slot limit to SLOTS; memories are not cleared.
`default_nettype none

module message_ring_fifo #(
   parameter  int SLOTS   = mrf_pkg::SLOTS_DEF,
   parameter  int MAX_LEN = mrf_pkg::MAX_LEN_DEF,
   localparam int CNT_W   = $clog2(SLOTS + 1),
   localparam int LEN_W   = $clog2(MAX_LEN + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire logic [1:0]       req_opcode,
   input  wire logic [7:0]       req_data_byte,
   input  wire logic             req_last_byte,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_out_last,
   output logic [LEN_W-1:0]      rsp_out_length,
   output logic [CNT_W-1:0]      rsp_queued_count,
   output logic                  rsp_is_empty,
   output logic                  rsp_is_full,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [CNT_W-1:0] csr_data
);

   mrf_pkg::cmd_type  cmd;
   mrf_pkg::stat_type stat;

   // Sequencer for requests and pop streams.
   mrf_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // Queue storage, indices and result registers.
   mrf_datapath #(
      .SLOTS   (SLOTS),
      .MAX_LEN (MAX_LEN)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_opcode       (req_opcode),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_last     (rsp_out_last),
      .rsp_out_length   (rsp_out_length),
      .rsp_queued_count (rsp_queued_count),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_is_full      (rsp_is_full),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

endmodule

`default_nettype wire

// ===== tb/tb_message_ring_fifo.sv =====
// Self-checking testbench for the message ring FIFO: directed table, then random phases.
module tb_message_ring_fifo;

   localparam int SLOTS   = mrf_pkg::SLOTS_DEF;
   localparam int MAX_LEN = mrf_pkg::MAX_LEN_DEF;

   // One result as the block reports it.
   typedef struct packed {
      mrf_pkg::status_type status;
      logic [7:0]          out_byte;
      logic                out_last;
      logic [3:0]          out_length;
      logic [4:0]          queued;
      logic                empty;
      logic                full;
   } fifo_reply_type;

   // One row of the directed table; fixed rows carry a hand-written result.
   typedef struct packed {
      mrf_pkg::op_type op;
      logic [7:0]      data;
      logic            fin;
      logic            fixed;
      fifo_reply_type  want;
   } directed_row_type;

   logic       clock;
   logic       reset         = 1'b1;
   logic       start         = 1'b0;
   logic [1:0] req_opcode    = 2'd0;
   logic [7:0] req_data_byte = 8'd0;
   logic       req_last_byte = 1'b0;
   logic       csr_valid     = 1'b0;
   logic [4:0] csr_data      = 5'd0;
   logic       busy;
   logic       rsp_valid;
   logic [1:0] rsp_status;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;
   logic [3:0] rsp_out_length;
   logic [4:0] rsp_queued_count;
   logic       rsp_is_empty;
   logic       rsp_is_full;
   logic       csr_ready;

   // Mirror of the queue state, updated at every accepted transaction.
   logic [7:0] mirror_bytes [SLOTS][MAX_LEN];
   logic [3:0] mirror_len [SLOTS];
   bit         len_defined [SLOTS];
   logic [3:0] head_ptr = 4'd0;
   logic [3:0] tail_ptr = 4'd0;
   logic [4:0] msg_count = 5'd0;
   logic [3:0] staged = 4'd0;
   bit         overflow_seen = 1'b0;
   bit         blocked_seen = 1'b0;
   logic [4:0] limit_reg = 5'd16;

   fifo_reply_type due_replies [$];
   bit             burst = 1'b0;
   int             mismatches = 0;
   int             requests_sent = 0;
   int             replies_seen = 0;
   int             busy_replies = 0;
   int             len_err_replies = 0;

   // Slot limits walked by the random phases, saturating values among them.
   logic [4:0] phase_limits [10] = '{5'd31, 5'd2, 5'd1, 5'd0, 5'd16,
                                     5'd3, 5'd17, 5'd8, 5'd16, 5'd5};

   directed_row_type steps [25] = '{
      '{mrf_pkg::OP_POP,   8'h00, 1'b0, 1'b1,
        '{mrf_pkg::ST_BUSY,    8'h00, 1'b1, 4'd0, 5'd0, 1'b1, 1'b0}},
      '{mrf_pkg::OP_CLEAR, 8'hFF, 1'b1, 1'b1,
        '{mrf_pkg::ST_OK,      8'h00, 1'b1, 4'd0, 5'd0, 1'b1, 1'b0}},
      '{mrf_pkg::OP_NOP,   8'hFF, 1'b0, 1'b1,
        '{mrf_pkg::ST_OK,      8'h00, 1'b1, 4'd0, 5'd0, 1'b1, 1'b0}},
      '{mrf_pkg::OP_PUSH,  8'h00, 1'b0, 1'b1,
        '{mrf_pkg::ST_PENDING, 8'h00, 1'b1, 4'd0, 5'd0, 1'b1, 1'b0}},
      '{mrf_pkg::OP_PUSH,  8'hFF, 1'b1, 1'b1,
        '{mrf_pkg::ST_OK,      8'h00, 1'b1, 4'd0, 5'd1, 1'b0, 1'b0}},
      '{mrf_pkg::OP_PUSH,  8'h80, 1'b0, 1'b0, '0},
      '{mrf_pkg::OP_PUSH,  8'h01, 1'b0, 1'b0, '0},
      '{mrf_pkg::OP_PUSH,  8'h7F, 1'b0, 1'b0, '0},
      '{mrf_pkg::OP_PUSH,  8'hFE, 1'b0, 1'b0, '0},
      '{mrf_pkg::OP_PUSH,  8'h55, 1'b0, 1'b0, '0},
      '{mrf_pkg::OP_PUSH,  8'hAA, 1'b0, 1'b0, '0},
      '{mrf_pkg::OP_PUSH,  8'h0F, 1'b0, 1'b0, '0},
      '{mrf_pkg::OP_PUSH,  8'hF0, 1'b1, 1'b0, '0},
      '{mrf_pkg::OP_PUSH,  8'h11, 1'b0, 1'b0, '0},
      '{mrf_pkg::OP_PUSH,  8'h22, 1'b0, 1'b0, '0},
      '{mrf_pkg::OP_PUSH,  8'h33, 1'b0, 1'b0, '0},
      '{mrf_pkg::OP_PUSH,  8'h44, 1'b0, 1'b0, '0},
      '{mrf_pkg::OP_PUSH,  8'hC3, 1'b0, 1'b0, '0},
      '{mrf_pkg::OP_PUSH,  8'h3C, 1'b0, 1'b0, '0},
      '{mrf_pkg::OP_PUSH,  8'h96, 1'b0, 1'b0, '0},
      '{mrf_pkg::OP_PUSH,  8'h69, 1'b0, 1'b0, '0},
      '{mrf_pkg::OP_PUSH,  8'hE7, 1'b1, 1'b1,
        '{mrf_pkg::ST_LEN_ERR, 8'h00, 1'b1, 4'd0, 5'd2, 1'b0, 1'b0}},
      '{mrf_pkg::OP_POP,   8'h5A, 1'b1, 1'b0, '0},
      '{mrf_pkg::OP_POP,   8'hA5, 1'b0, 1'b0, '0},
      '{mrf_pkg::OP_POP,   8'h00, 1'b0, 1'b1,
        '{mrf_pkg::ST_BUSY,    8'h00, 1'b1, 4'd0, 5'd0, 1'b1, 1'b0}}
   };

   message_ring_fifo uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_last     (rsp_out_last),
      .rsp_out_length   (rsp_out_length),
      .rsp_queued_count (rsp_queued_count),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_is_full      (rsp_is_full),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The programmed limit, saturated into 1..SLOTS.
   function automatic logic [4:0] eff_limit();
      if (limit_reg == 5'd0) return 5'd1;
      if (limit_reg > SLOTS) return 5'(SLOTS);
      return limit_reg;
   endfunction

   // Ring indices wrap to zero once they reach the limit.
   function automatic logic [3:0] next_slot(logic [3:0] idx);
      logic [4:0] n;
      n = idx + 5'd1;
      return (n >= eff_limit()) ? 4'd0 : n[3:0];
   endfunction

   // Builds one result with the count and flags of the current queue state.
   function automatic fifo_reply_type make_reply(mrf_pkg::status_type st, logic [7:0] b,
                                                 logic fin, logic [3:0] len);
      fifo_reply_type r;
      r.status     = st;
      r.out_byte   = b;
      r.out_last   = fin;
      r.out_length = len;
      r.queued     = msg_count;
      r.empty      = (msg_count == 5'd0);
      r.full       = (msg_count >= eff_limit());
      return r;
   endfunction

   // Advances the mirror by one transaction and queues the results it causes.
   task automatic apply_fifo_op(input mrf_pkg::op_type op, input logic [7:0] b,
                                input logic fin);
      mrf_pkg::status_type st;
      logic [3:0]          slot;
      logic [3:0]          len;
      int                  i;
      case (op)
         mrf_pkg::OP_PUSH: begin
            if (msg_count >= eff_limit()) blocked_seen = 1'b1;
            if (staged >= MAX_LEN) begin
               overflow_seen = 1'b1;
            end else begin
               if (!blocked_seen) mirror_bytes[tail_ptr][staged] = b;
               staged = staged + 4'd1;
            end
            if (!fin) begin
               due_replies.push_back(make_reply(mrf_pkg::ST_PENDING, 8'd0, 1'b1, 4'd0));
            end else begin
               // A length error wins over a full queue; both drop the message.
               if (overflow_seen) begin
                  st = mrf_pkg::ST_LEN_ERR;
               end else if (blocked_seen) begin
                  st = mrf_pkg::ST_BUSY;
               end else begin
                  mirror_len[tail_ptr]  = staged;
                  len_defined[tail_ptr] = 1'b1;
                  tail_ptr  = next_slot(tail_ptr);
                  msg_count = msg_count + 5'd1;
                  st = mrf_pkg::ST_OK;
               end
               staged = 4'd0;
               overflow_seen = 1'b0;
               blocked_seen = 1'b0;
               due_replies.push_back(make_reply(st, 8'd0, 1'b1, 4'd0));
            end
         end
         mrf_pkg::OP_POP: begin
            if (msg_count == 5'd0) begin
               due_replies.push_back(make_reply(mrf_pkg::ST_BUSY, 8'd0, 1'b1, 4'd0));
            end else begin
               slot = head_ptr;
               len  = mirror_len[slot];
               mirror_len[slot] = 4'd0;
               head_ptr  = next_slot(head_ptr);
               msg_count = msg_count - 5'd1;
               // A slot already popped answers with a single empty result.
               if (len == 4'd0) begin
                  due_replies.push_back(make_reply(mrf_pkg::ST_OK, 8'd0, 1'b1, 4'd0));
               end else begin
                  for (i = 0; i < len; i++) begin
                     due_replies.push_back(make_reply(mrf_pkg::ST_OK, mirror_bytes[slot][i],
                                                      (i + 1 == len), len));
                  end
               end
            end
         end
         mrf_pkg::OP_CLEAR: begin
            head_ptr = 4'd0;
            tail_ptr = 4'd0;
            msg_count = 5'd0;
            staged = 4'd0;
            overflow_seen = 1'b0;
            blocked_seen = 1'b0;
            due_replies.push_back(make_reply(mrf_pkg::ST_OK, 8'd0, 1'b1, 4'd0));
         end
         default: begin
            due_replies.push_back(make_reply(mrf_pkg::ST_OK, 8'd0, 1'b1, 4'd0));
         end
      endcase
   endtask

   // Drives one request transaction from a falling edge, waits for acceptance,
   // then idles for a drawn number of cycles. Returns at a falling edge.
   task automatic send_request(input mrf_pkg::op_type op, input logic [7:0] b,
                               input logic fin, input bit fixed,
                               input fifo_reply_type want);
      int gap;
      start         <= 1'b1;
      req_opcode    <= op;
      req_data_byte <= b;
      req_last_byte <= fin;
      @(posedge clock);
      while (busy) @(posedge clock);
      apply_fifo_op(op, b, fin);
      // A hand-written result takes the place of the predicted one.
      if (fixed) begin
         void'(due_replies.pop_back());
         due_replies.push_back(want);
      end
      requests_sent++;
      gap = burst ? 0 : $urandom_range(0, 7);
      @(negedge clock);
      if (gap != 0) begin
         start         <= 1'b0;
         req_opcode    <= 2'($urandom);
         req_data_byte <= 8'($urandom);
         req_last_byte <= 1'($urandom);
         repeat (gap) @(negedge clock);
      end
   endtask

   // Holds off new requests until every expected result has arrived.
   task automatic settle();
      start <= 1'b0;
      do @(negedge clock); while (due_replies.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // Compare every result with the oldest expectation.
   always @(posedge clock) begin
      fifo_reply_type got;
      fifo_reply_type want;
      if (!reset && rsp_valid) begin
         got = '{mrf_pkg::status_type'(rsp_status), rsp_out_byte, rsp_out_last,
                 rsp_out_length, rsp_queued_count, rsp_is_empty, rsp_is_full};
         replies_seen++;
         if (got.status == mrf_pkg::ST_BUSY) busy_replies++;
         if (got.status == mrf_pkg::ST_LEN_ERR) len_err_replies++;
         if (due_replies.size() == 0) begin
            $error("result with no expectation waiting: status %0d byte %0d",
                   got.status, got.out_byte);
            mismatches++;
         end else begin
            want = due_replies.pop_front();
            check_field("status", want.status, got.status);
            check_field("out_byte", want.out_byte, got.out_byte);
            check_field("out_last", want.out_last, got.out_last);
            check_field("out_length", want.out_length, got.out_length);
            check_field("queued_count", want.queued, got.queued);
            check_field("is_empty", want.empty, got.empty);
            check_field("is_full", want.full, got.full);
         end
      end
   end

   // Stimulus: reset, the directed table, then random phases at several limits.
   initial begin
      int              p;
      int              done;
      int              roll;
      int              msg_left;
      mrf_pkg::op_type op;
      logic [7:0]      b;
      logic            fin;
      msg_left = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (steps[i]) begin
         send_request(steps[i].op, steps[i].data, steps[i].fin, steps[i].fixed,
                      steps[i].want);
      end
      settle();

      for (p = 0; p < 10; p++) begin
         // Reprogram the slot limit while the block is idle; stored messages stay.
         csr_valid <= 1'b1;
         csr_data  <= phase_limits[p];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         limit_reg = phase_limits[p];
         @(negedge clock);
         csr_valid <= 1'b0;
         burst = (p % 3 == 1);

         done = 0;
         while (done < 44) begin
            if ($urandom_range(0, 31) == 0) settle();
            roll = $urandom_range(0, 99);
            b    = 8'($urandom);
            fin  = 1'b0;
            if (msg_left > 0 && roll < 85) begin
               op  = mrf_pkg::OP_PUSH;
               fin = (msg_left == 1);
               msg_left--;
            end else if (msg_left == 0 && roll < 45) begin
               // Mostly legal lengths, now and then one that overflows.
               msg_left = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_LEN + 1, MAX_LEN + 3)
                                                      : $urandom_range(1, MAX_LEN);
               op  = mrf_pkg::OP_PUSH;
               fin = (msg_left == 1);
               msg_left--;
            end else if (roll < 89) begin
               op = mrf_pkg::OP_POP;
            end else if (roll < 93) begin
               op = mrf_pkg::OP_CLEAR;
            end else if (roll < 96) begin
               op = mrf_pkg::OP_NOP;
            end else begin
               op  = mrf_pkg::OP_PUSH;
               fin = 1'($urandom);
            end
            // Never pop a slot whose length was never written.
            if (op == mrf_pkg::OP_POP && msg_count != 5'd0 && !len_defined[head_ptr]) begin
               op = mrf_pkg::OP_NOP;
            end
            send_request(op, b, fin, 1'b0, '0);
            if (op != mrf_pkg::OP_NOP) done++;
         end
         settle();
      end

      $display("Run covered %0d transactions and %0d results over %0d slot-limit phases,",
               requests_sent, replies_seen, $size(phase_limits));
      $display("including %0d busy and %0d length-error results.",
               busy_replies, len_err_replies);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2000000;
      $display("Timeout: the run did not finish in time.");
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/mrf_pkg.sv
hdl/mrf_ctrl.sv
hdl/mrf_datapath.sv
hdl/message_ring_fifo.sv
tb/tb_message_ring_fifo.sv
